/* hdl/dsrm_pkg.sv */
// ----------------------------------------------------------------------------
// dsrm_pkg
// Shared constants, types and the star-closure function of the matcher.
// ----------------------------------------------------------------------------
package dsrm_pkg;

  localparam int MAX_TOKENS  = 32;
  localparam int TOKEN_REGS  = 32;
  localparam int TOKEN_LIMIT = (MAX_TOKENS < TOKEN_REGS) ? MAX_TOKENS : TOKEN_REGS;
  localparam int NPOS        = TOKEN_REGS + 1;
  localparam int CNT_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int CHARS_PER_REG = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_CHARS_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_CHARS_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_CHARS_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_CHARS_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STAR_MASK     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_COUNT   = 3'd5;

  // Character codes
  localparam logic [7:0] CHAR_NUL = 8'd0;
  localparam logic [7:0] CHAR_DOT = 8'd46;

  typedef struct packed {
    logic [TOKEN_REGS-1:0][7:0] chars;
    logic [TOKEN_REGS-1:0]      star;
    logic [CNT_W-1:0]           count;
  } dsrm_cfg_t;

  // One classified text byte as queued between front and back
  typedef struct packed {
    logic                  is_end;
    logic [TOKEN_REGS-1:0] hit;
  } dsrm_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dsrm_qstat_t;

  // Star closure as a parallel prefix: a live position j-1 whose token is
  // starred makes position j live, transitively.
  function automatic logic [NPOS-1:0] close_set(input logic [NPOS-1:0] set,
                                                input logic [TOKEN_REGS-1:0] star);
    logic [NPOS-1:0] g;
    logic [NPOS-1:0] p;
    logic [NPOS-1:0] g2;
    logic [NPOS-1:0] p2;
    g = set;
    p = {star, 1'b0};
    for (int d = 1; d < NPOS; d = d * 2) begin
      g2 = g;
      p2 = p;
      for (int j = d; j < NPOS; j++) begin
        g2[j] = g[j] | (p[j] & g[j-d]);
        p2[j] = p[j] & p[j-d];
      end
      g = g2;
      p = p2;
    end
    return g;
  endfunction

endpackage

/* hdl/dot_star_regex_matcher.sv */
// ----------------------------------------------------------------------------
// dot_star_regex_matcher
// Whole-string matcher for patterns of literal, '.' and starred tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Load the pattern through the cfg_ channel (index 0..3 token characters,
//   8 per register, low byte first; 4 star mask; 5 token count) while no text
//   is in flight. cfg_ready is always high; indexes above 5 are ignored.
//   Stream text bytes on in_; every transaction carries one byte. A zero
//   byte ends the text: it produces one out_ transaction whose bit 0 is 1
//   when the whole text matched the whole pattern, and rearms the engine.
//   Other bytes produce nothing on out_.
// Timing:
//   One byte per cycle sustained while no zero byte is held behind a waiting
//   result. The front classifies each byte against all tokens and queues it;
//   the back applies the position-set update with both star closures
//   combinationally. A zero byte is queued when accepted, and the automaton
//   step loads the result register from the queue head.
// Reset:
//   rst_n clears the pattern registers, the queue and the result register,
//   and leaves only position zero live.
// Stalls:
//   While a result waits on out_tready, ordinary bytes keep flowing; a second
//   zero byte waits in the two-entry queue, and in_tready drops when full.
// ----------------------------------------------------------------------------
module dot_star_regex_matcher (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] text_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [0] matched, [7:1] zero
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dsrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsrm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dsrm_pkg::*;

  dsrm_cfg_t   cfg;
  dsrm_item_t  push_item;
  dsrm_item_t  head;
  dsrm_qstat_t q_stat;
  logic        push;
  logic        pop;

  // Pattern registers
  dsrm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // Accept and classify bytes
  dsrm_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_i     (cfg),
    .q_stat    (q_stat),
    .push      (push),
    .item      (push_item)
  );

  // Decouple front from back
  dsrm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Advance the automaton and register results
  dsrm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Queue can never be full and empty at once
  assert property (@(posedge clk) disable iff (!rst_n) !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // Back never takes an item from an empty queue
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // Reset leaves the queue empty
  assert property (@(posedge clk) !rst_n |=> q_stat.empty)
    else $error("queue not empty after reset");

endmodule

/* hdl/dsrm_cfg.sv */
// ----------------------------------------------------------------------------
// dsrm_cfg
// Pattern register file: token characters, star mask and token count.
// ----------------------------------------------------------------------------
module dsrm_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dsrm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dsrm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output dsrm_pkg::dsrm_cfg_t                cfg_o
);
  import dsrm_pkg::*;

  dsrm_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TOKEN_CHARS_0, CFG_TOKEN_CHARS_1, CFG_TOKEN_CHARS_2,
        CFG_TOKEN_CHARS_3: begin
          for (int b = 0; b < CHARS_PER_REG; b++) begin
            cfg_r.chars[{cfg_index[1:0], 3'(b)}] <= cfg_data[8*b +: 8];
          end
        end
        CFG_STAR_MASK: begin
          cfg_r.star <= cfg_data[TOKEN_REGS-1:0];
        end
        CFG_TOKEN_COUNT: begin
          cfg_r.count <= cfg_data[CNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* hdl/dsrm_front.sv */
// ----------------------------------------------------------------------------
// dsrm_front
// Input side: accept text bytes and classify them against every token.
// ----------------------------------------------------------------------------
module dsrm_front (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  dsrm_pkg::dsrm_cfg_t   cfg_i,
  input  dsrm_pkg::dsrm_qstat_t q_stat,
  output logic                  push,
  output dsrm_pkg::dsrm_item_t  item
);
  import dsrm_pkg::*;

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;

  // Per-token hit: wildcard or equal character
  always_comb begin
    item.is_end = (in_tdata == CHAR_NUL);
    for (int i = 0; i < TOKEN_REGS; i++) begin
      item.hit[i] = (cfg_i.chars[i] == CHAR_DOT) || (cfg_i.chars[i] == in_tdata);
    end
  end

endmodule

/* hdl/dsrm_queue.sv */
// ----------------------------------------------------------------------------
// dsrm_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module dsrm_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dsrm_pkg::dsrm_item_t  push_item,
  input  logic                  pop,
  output dsrm_pkg::dsrm_item_t  head,
  output dsrm_pkg::dsrm_qstat_t q_stat
);
  import dsrm_pkg::*;

  dsrm_item_t mem_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, rd_ptr_r;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

endmodule

/* hdl/dsrm_back.sv */
// ----------------------------------------------------------------------------
// dsrm_back
// Position-set automaton and result register.
// ----------------------------------------------------------------------------
module dsrm_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dsrm_pkg::dsrm_cfg_t   cfg_i,
  input  dsrm_pkg::dsrm_item_t  head,
  input  dsrm_pkg::dsrm_qstat_t q_stat,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata
);
  import dsrm_pkg::*;

  logic [NPOS-1:0]       active_r, active_nxt;
  logic [NPOS-1:0]       cur, next_set, pos_mask;
  logic [TOKEN_REGS-1:0] star_eff, lt_n, fire;
  logic [CNT_W-1:0]      n_use;
  logic                  out_valid_r, out_valid_nxt;
  logic                  matched_r;

  // Saturate token count to the token limit
  assign n_use = (cfg_i.count > CNT_W'(TOKEN_LIMIT)) ? CNT_W'(TOKEN_LIMIT) : cfg_i.count;

  always_comb begin
    for (int j = 0; j < NPOS; j++) begin
      pos_mask[j] = ((CNT_W+1)'(j) <= {1'b0, n_use});
    end
    for (int i = 0; i < TOKEN_REGS; i++) begin
      lt_n[i] = ((CNT_W+1)'(i) < {1'b0, n_use});
    end
  end

  assign star_eff = cfg_i.star & lt_n;
  assign cur      = close_set(active_r & pos_mask, star_eff);
  assign fire     = cur[TOKEN_REGS-1:0] & head.hit & lt_n;
  // Starred hit stays on its position, plain hit advances one
  assign next_set = {1'b0, fire & cfg_i.star} | {fire & ~cfg_i.star, 1'b0};

  // Hold an end item while its result cannot be registered
  assign pop = !q_stat.empty && (!head.is_end || !out_valid_r || out_tready);

  always_comb begin
    active_nxt = active_r;
    if (pop) begin
      if (head.is_end) begin
        active_nxt = NPOS'(1);
      end else begin
        active_nxt = close_set(next_set & pos_mask, star_eff);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && head.is_end) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matched_r <= 1'b0;
    end else if (pop && head.is_end) begin
      matched_r <= cur[n_use];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= NPOS'(1);
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, matched_r};

endmodule
